// ===== hdl/assert_macros.svh =====
// Assertion helper macros for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock, disabled during reset
`define ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

// ===== hdl/mvt_pkg.sv =====
//------------------------------------------------------------------------------
// mvt_pkg
// Shared types, constants and float helper functions for the 4x4 transform.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mvt_pkg;

   localparam int unsigned NumRegs   = 8;
   localparam int unsigned RegIdxW   = 3;
   localparam int unsigned CsrDataW  = 64;
   localparam int unsigned FloatW    = 32;
   localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
   localparam logic [31:0] QuietBit   = 32'h0040_0000;

   typedef logic [FloatW-1:0] float_type;

   // Product pre-rounding form: special result or unrounded magnitude
   typedef struct packed {
      logic        special;     // result fully given by spec_val
      float_type   spec_val;
      logic        sign;
      logic signed [10:0] exp;  // biased exponent of bit 47 position
      logic [47:0] mant;        // raw 24x24 product
   } mul_mid_type;

   function automatic logic is_nan(input float_type a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input float_type a);
      return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
   endfunction

   function automatic logic is_zero(input float_type a);
      return a[30:0] == 31'd0;
   endfunction

   // Round a sign / biased exponent / 27-bit significand (bit 26 is the hidden
   // position, bit 0 is sticky) to binary32, nearest even. exp is the exponent
   // for bit 26; values below 1 are shifted into the subnormal range.
   function automatic float_type round_pack(input logic sign,
                                            input logic signed [11:0] exp,
                                            input logic [26:0] sig);
      logic [26:0] s;
      logic [5:0]  sh;
      logic        st;
      logic [24:0] r;
      logic signed [11:0] e;
      logic        inc;
      s = sig;
      e = exp;
      if (e < 12'sd1) begin
         if (e < -12'sd30) sh = 6'd31;
         else sh = 6'(12'sd1 - e);
         st = 1'b0;
         for (int i = 0; i < 27; i++) if (i < int'(sh) && s[i]) st = 1'b1;
         s = (sh > 6'd26) ? 27'd0 : (s >> sh);
         s[0] = s[0] | st;
         e = 12'sd0;
      end
      inc = s[2] & (s[1] | s[0] | s[3]);
      r = {1'b0, s[26:3]} + {24'd0, inc};
      if (r[24]) begin
         r = r >> 1;
         e = e + 12'sd1;
      end else if (e == 12'sd0 && r[23]) begin
         e = 12'sd1;
      end
      if (e >= 12'sd255) return {sign, 8'hFF, 23'd0};
      return {sign, e[7:0], r[22:0]};
   endfunction

endpackage
`default_nettype wire

// ===== hdl/mvt_if.sv =====
//------------------------------------------------------------------------------
// mvt_req_if / mvt_rsp_if
// Valid/ready channels carrying the input and result vectors.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface mvt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] x_in;
   logic [31:0] y_in;
   logic [31:0] z_in;
   logic [31:0] w_in;
   modport source (output valid, x_in, y_in, z_in, w_in, input ready);
   modport sink   (input valid, x_in, y_in, z_in, w_in, output ready);
endinterface

interface mvt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] x_out;
   logic [31:0] y_out;
   logic [31:0] z_out;
   logic [31:0] w_out;
   modport source (output valid, x_out, y_out, z_out, w_out, input ready);
   modport sink   (input valid, x_out, y_out, z_out, w_out, output ready);
endinterface
`default_nettype wire

// ===== hdl/mvt_fmul.sv =====
//------------------------------------------------------------------------------
// mvt_fmul
// Two-stage binary32 multiplier with a stall enable.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mvt_fmul
   import mvt_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      en,
   input  wire float_type a,
   input  wire float_type b,
   output float_type      p
);

   mul_mid_type mid_in, mid_ff;
   float_type   p_ff, p_in;

   // stage 1: specials and raw significand product
   always_comb begin
      logic [23:0] ma, mb;
      logic [7:0]  ea, eb;
      mid_in = '0;
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      mid_in.sign = a[31] ^ b[31];
      mid_in.exp  = 11'(signed'({3'd0, ea})) + 11'(signed'({3'd0, eb})) - 11'sd126;
      mid_in.mant = ma * mb;
      if (is_nan(a)) begin
         mid_in.special = 1'b1; mid_in.spec_val = a | QuietBit;
      end else if (is_nan(b)) begin
         mid_in.special = 1'b1; mid_in.spec_val = b | QuietBit;
      end else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) begin
         mid_in.special = 1'b1; mid_in.spec_val = DefaultNan;
      end else if (is_inf(a) || is_inf(b)) begin
         mid_in.special = 1'b1; mid_in.spec_val = {mid_in.sign, 8'hFF, 23'd0};
      end else if (is_zero(a) || is_zero(b)) begin
         mid_in.special = 1'b1; mid_in.spec_val = {mid_in.sign, 31'd0};
      end
   end

   // stage 2: normalize (leading-one search over the 48-bit product) and round
   always_comb begin
      logic [47:0] m;
      logic signed [11:0] e;
      logic [5:0] lz;
      m = mid_ff.mant;
      e = 12'(mid_ff.exp);
      lz = 6'd0;
      for (int i = 47; i >= 0; i--) if (m[i] && lz == 6'd0) lz = 6'(47 - i) | 6'd0;
      // lz may be nonzero when bit47 set; the shift below is guarded on bit47
      if (!m[47]) begin
         m = m << lz;
         e = e - 12'(lz);
      end
      p_in = mid_ff.special ? mid_ff.spec_val
                            : round_pack(mid_ff.sign, e, {m[47:22], |m[21:0]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mid_ff <= mid_in;
         p_ff   <= p_in;
      end
   end

   assign p = p_ff;

endmodule
`default_nettype wire

// ===== hdl/mvt_fadd.sv =====
//------------------------------------------------------------------------------
// mvt_fadd
// Two-stage binary32 adder with a stall enable.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mvt_fadd
   import mvt_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      en,
   input  wire float_type a,
   input  wire float_type b,
   output float_type      s
);

   logic        spec_ff, spec_in;
   float_type   sval_ff, sval_in;
   logic        sign_ff, sign_in;
   logic [7:0]  exp_ff, exp_in;
   logic [27:0] sum_ff, sum_in;
   float_type   s_ff, s_in;

   // stage 1: specials, align and add/subtract magnitudes
   always_comb begin
      float_type big, lit;
      logic [7:0] eb, el, d;
      logic [26:0] mb, ml, shl;
      logic st;
      if (a[30:0] >= b[30:0]) begin big = a; lit = b; end
      else begin big = b; lit = a; end
      eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      el = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
      mb = {big[30:23] != 8'd0, big[22:0], 3'd0};
      ml = {lit[30:23] != 8'd0, lit[22:0], 3'd0};
      d = eb - el;
      st = 1'b0;
      for (int i = 0; i < 27; i++) if (i < int'(d) && ml[i]) st = 1'b1;
      shl = (d > 8'd26) ? 27'd0 : (ml >> d);
      shl[0] = shl[0] | st;
      sign_in = big[31];
      exp_in  = eb;
      sum_in  = (a[31] ^ b[31]) ? ({1'b0, mb} - {1'b0, shl}) : ({1'b0, mb} + {1'b0, shl});
      spec_in = 1'b1;
      sval_in = '0;
      if (is_nan(a)) sval_in = a | QuietBit;
      else if (is_nan(b)) sval_in = b | QuietBit;
      else if (is_inf(a) && is_inf(b) && (a[31] != b[31])) sval_in = DefaultNan;
      else if (is_inf(a)) sval_in = a;
      else if (is_inf(b)) sval_in = b;
      else if (is_zero(a) && is_zero(b)) sval_in = {a[31] & b[31], 31'd0};
      else if ((a[31] ^ b[31]) && a[30:0] == b[30:0]) sval_in = '0;
      else spec_in = 1'b0;
   end

   // stage 2: normalize and round
   always_comb begin
      logic [27:0] m;
      logic signed [11:0] e;
      logic [4:0] lz;
      logic found;
      m = sum_ff;
      e = 12'(signed'({4'd0, exp_ff}));
      lz = 5'd0;
      found = 1'b0;
      if (m[27]) begin
         m = {1'b0, m[27:2], m[1] | m[0]};
         e = e + 12'sd1;
      end else begin
         for (int i = 26; i >= 0; i--) begin
            if (m[i] && !found) begin lz = 5'(26 - i); found = 1'b1; end
         end
         m = m << lz;
         e = e - 12'(lz);
      end
      s_in = spec_ff ? sval_ff : round_pack(sign_ff, e, m[26:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spec_ff <= spec_in;
         sval_ff <= sval_in;
         sign_ff <= sign_in;
         exp_ff  <= exp_in;
         sum_ff  <= sum_in;
         s_ff    <= s_in;
      end
   end

   assign s = s_ff;

endmodule
`default_nettype wire

// ===== hdl/mvt_lane.sv =====
//------------------------------------------------------------------------------
// mvt_lane
// One row lane: four multipliers then the adder chain p0+(p1+(p2+p3)).
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mvt_lane
   import mvt_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      en,
   input  wire float_type m0, m1, m2, m3,
   input  wire float_type v0, v1, v2, v3,
   output float_type      dot
);

   float_type p0, p1, p2, p3, s23, s123;
   float_type p0_d1_ff, p0_d2_ff, p0_d3_ff, p0_d4_ff;
   float_type p1_d1_ff, p1_d2_ff;

   mvt_fmul u_m0 (.clock, .en, .a(m0), .b(v0), .p(p0));
   mvt_fmul u_m1 (.clock, .en, .a(m1), .b(v1), .p(p1));
   mvt_fmul u_m2 (.clock, .en, .a(m2), .b(v2), .p(p2));
   mvt_fmul u_m3 (.clock, .en, .a(m3), .b(v3), .p(p3));

   mvt_fadd u_a23  (.clock, .en, .a(p2), .b(p3), .s(s23));
   mvt_fadd u_a123 (.clock, .en, .a(p1_d2_ff), .b(s23), .s(s123));
   mvt_fadd u_a0   (.clock, .en, .a(p0_d4_ff), .b(s123), .s(dot));

   // delay lines keep left terms aligned with the chain
   always_ff @(posedge clock) begin
      if (en) begin
         p1_d1_ff <= p1;       p1_d2_ff <= p1_d1_ff;
         p0_d1_ff <= p0;       p0_d2_ff <= p0_d1_ff;
         p0_d3_ff <= p0_d2_ff; p0_d4_ff <= p0_d3_ff;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/matrix_vector_transform_4x4.sv =====
//------------------------------------------------------------------------------
// matrix_vector_transform_4x4
// Streams 4-component binary32 vectors through a configured 4x4 matrix.
//------------------------------------------------------------------------------
// Usage:
//  - Load the matrix through csr_: index 2*r+h holds row r, columns 2h (low
//    half) and 2h+1 (high half). All eight indexes are in range. Write only
//    while the pipeline is empty.
//  - req_ carries one vector request (x,y,z,w); rsp_ returns one result vector.
//  - Four row lanes run side by side; each has four 2-stage multipliers and a
//    chain of three 2-stage adders, followed by the output register that
//    drives rsp_valid.
//  - Throughput: one request per cycle. The whole pipeline advances while the
//    output register is empty or being drained.
//  - When the receiver stalls the pipeline freezes and req_ready drops;
//    no result is lost.
//  - Reset clears the matrix to +0.0 and all valid bits.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module matrix_vector_transform_4x4
   import mvt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [RegIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata,
   mvt_req_if.sink                  req,
   mvt_rsp_if.source                rsp
);

   localparam int unsigned Depth = 8;

   logic [CsrDataW-1:0] regs_ff [NumRegs];
   logic [Depth-1:0]    vld_ff;
   logic                en;
   float_type           dot [4];
   logic                rsp_valid_ff;

   // pipeline moves when the output register is empty or draining
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) regs_ff[i] <= '0;
      end else if (csr_we) begin
         regs_ff[csr_index] <= csr_wdata;
      end
   end

   for (genvar r = 0; r < 4; r++) begin : g_lane
      mvt_lane u_lane (
         .clock, .en,
         .m0(regs_ff[2*r][31:0]),   .m1(regs_ff[2*r][63:32]),
         .m2(regs_ff[2*r+1][31:0]), .m3(regs_ff[2*r+1][63:32]),
         .v0(req.x_in), .v1(req.y_in), .v2(req.z_in), .v3(req.w_in),
         .dot(dot[r]));
   end

   // valid shadow of the lanes
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[Depth-2:0], req.valid};
   end

   // output register merges the lanes into one result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[Depth-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp.x_out <= dot[0];
         rsp.y_out <= dot[1];
         rsp.z_out <= dot[2];
         rsp.w_out <= dot[3];
      end
   end
   assign rsp.valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== hdl/mvt_checker.sv =====
//------------------------------------------------------------------------------
// mvt_checker
// Port-level checks on the transform, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mvt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_x_out
);
   `ASSERT_NEXT(a_rst_idle, clock, 1'b0, reset, !rsp_valid, "rsp valid after reset")
   `ASSERT_IMPL(a_rst_block, clock, 1'b0, reset, !(req_valid && req_ready), "request taken in reset")
   `ASSERT_IMPL(a_ready_free, clock, reset, !rsp_valid, req_ready, "ready low with empty output")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_x_out), "rsp dropped while stalled")
endmodule

bind matrix_vector_transform_4x4 mvt_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_x_out(rsp.x_out));
`default_nettype wire
